### hw/rtl/afrc_pkg.sv
`timescale 1ns / 1ps
package afrc_pkg;

    localparam int MAX_FACTOR = 64;
    localparam int FACTOR_W   = $clog2(MAX_FACTOR + 1);
    localparam int SAMPLE_W   = 32;
    localparam int DIFF_W     = SAMPLE_W + 1;
    localparam int DIV_CNT_W  = $clog2(DIFF_W);
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    localparam int CFG_DATA_W = 7;
    localparam int CFG_IDX_W  = 2;

    localparam logic MODE_SPEED_UP  = 1'b0;
    localparam logic MODE_SLOW_DOWN = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE     = 2'd0,
        CFG_FACTOR   = 2'd1,
        CFG_CHANNELS = 2'd2,
        CFG_BYTES    = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic                mode;
        logic [FACTOR_W-1:0] factor;
        logic                two;
        logic [2:0]          nbytes;
    } t_cfg;

    typedef struct packed {
        logic                interp;
        logic [SAMPLE_W-1:0] cur_l;
        logic [SAMPLE_W-1:0] cur_r;
        logic [SAMPLE_W-1:0] prev_l;
        logic [SAMPLE_W-1:0] prev_r;
        logic [FACTOR_W-1:0] factor;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_stat;

    typedef struct packed {
        logic interp_run;
        logic cmd_interp;
    } t_back_stat;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_INTERP,
        BK_LAST
    } t_back_state;

    // sign-extend the low nb bytes of a big-endian sample word
    function automatic logic [SAMPLE_W-1:0] sext_bytes(input logic [SAMPLE_W-1:0] raw,
                                                       input logic [2:0] nb);
        logic [SAMPLE_W-1:0] res;
        unique case (nb)
            3'd1:    res = {{24{raw[7]}}, raw[7:0]};
            3'd2:    res = {{16{raw[15]}}, raw[15:0]};
            3'd3:    res = {{8{raw[23]}}, raw[23:0]};
            default: res = raw;
        endcase
        return res;
    endfunction

endpackage

### hw/rtl/afrc_front.sv
`timescale 1ns / 1ps
module afrc_front
    import afrc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cfg                i_cfg,
    input  logic                i_valid,
    input  logic                i_full,
    input  logic [SAMPLE_W-1:0] i_sample_left,
    input  logic [SAMPLE_W-1:0] i_sample_right,
    input  logic                i_stream_start,
    output logic                o_push,
    output t_cmd                o_cmd
);

    logic [FACTOR_W-1:0] r_phase, n_phase;
    logic [SAMPLE_W-1:0] r_prev_l, r_prev_r;
    logic                w_acc;
    logic [SAMPLE_W-1:0] w_cl, w_cr;
    logic [FACTOR_W-1:0] w_inc;

    always_comb begin
        w_acc   = i_valid & ~i_full;
        w_cl    = sext_bytes(i_sample_left, i_cfg.nbytes);
        w_cr    = i_cfg.two ? sext_bytes(i_sample_right, i_cfg.nbytes) : '0;
        w_inc   = r_phase + FACTOR_W'(1);
        n_phase = r_phase;
        o_push  = 1'b0;

        o_cmd.interp = 1'b0;
        o_cmd.cur_l  = w_cl;
        o_cmd.cur_r  = w_cr;
        o_cmd.prev_l = r_prev_l;
        // one channel: right lane interpolates zero to zero
        o_cmd.prev_r = i_cfg.two ? r_prev_r : '0;
        o_cmd.factor = i_cfg.factor;

        if (w_acc) begin
            if (i_stream_start) begin
                n_phase = '0;
                o_push  = 1'b1;
            end else if (i_cfg.mode == MODE_SPEED_UP) begin
                if (w_inc >= i_cfg.factor) begin
                    n_phase = '0;
                    o_push  = 1'b1;
                end else begin
                    n_phase = w_inc;
                end
            end else begin
                n_phase      = '0;
                o_push       = 1'b1;
                o_cmd.interp = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= '0;
            r_prev_l <= '0;
            r_prev_r <= '0;
        end else begin
            r_phase <= n_phase;
            if (w_acc) begin
                r_prev_l <= w_cl;
                r_prev_r <= w_cr;
            end
        end
    end

endmodule

### hw/rtl/afrc_fifo.sv
`timescale 1ns / 1ps
module afrc_fifo
    import afrc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_cmd       i_data,
    input  logic       i_pop,
    output t_cmd       o_data,
    output t_fifo_stat o_stat
);

    t_cmd               r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wp, r_rp;
    logic [FIFO_AW:0]   r_cnt;

    assign o_data       = r_mem[r_rp];
    assign o_stat.full  = (r_cnt == (FIFO_AW+1)'(FIFO_DEPTH));
    assign o_stat.empty = (r_cnt == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + FIFO_AW'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + FIFO_AW'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + (FIFO_AW+1)'(1);
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - (FIFO_AW+1)'(1);
            end
        end
    end

endmodule

### hw/rtl/afrc_back.sv
`timescale 1ns / 1ps
module afrc_back
    import afrc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cmd                i_cmd,
    input  logic                i_cmd_valid,
    output logic                o_pop,
    input  logic                i_ready,
    output logic                o_valid,
    output logic [SAMPLE_W-1:0] o_left,
    output logic [SAMPLE_W-1:0] o_right,
    output logic                o_last,
    output t_back_stat          o_stat
);

    t_back_state r_state, n_state;
    t_cmd        r_cmd;

    // per-lane divider and interpolation accumulators
    logic                 r_neg [2];
    logic [DIFF_W-1:0]    r_dvd [2];
    logic [FACTOR_W-1:0]  r_rem [2];
    logic [DIFF_W-1:0]    r_q   [2];
    logic [FACTOR_W-1:0]  r_r   [2];
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [FACTOR_W-1:0]  r_j;

    logic                r_ovalid;
    logic [SAMPLE_W-1:0] r_out [2];
    logic                r_olast;

    logic                w_adv;
    logic [SAMPLE_W-1:0] w_cur  [2];
    logic [SAMPLE_W-1:0] w_prev [2];
    logic [SAMPLE_W-1:0] w_icur [2];
    logic [SAMPLE_W-1:0] w_iprev[2];
    logic [DIFF_W-1:0]   w_diff [2];
    logic [DIFF_W-1:0]   w_mag  [2];
    logic [FACTOR_W:0]   w_rsh  [2];
    logic                w_qbit [2];
    logic [FACTOR_W-1:0] w_nrem [2];
    logic [DIFF_W-1:0]   w_ndvd [2];
    logic [FACTOR_W:0]   w_rsum [2];
    logic                w_wrap [2];
    logic [DIFF_W-1:0]   w_off  [2];
    logic [SAMPLE_W-1:0] w_ival [2];
    logic                w_load_cmd, w_div_run, w_div_done, w_emit_i, w_emit_last;

    assign w_adv = ~r_ovalid | i_ready;

    always_comb begin
        w_cur[0]   = r_cmd.cur_l;
        w_cur[1]   = r_cmd.cur_r;
        w_prev[0]  = r_cmd.prev_l;
        w_prev[1]  = r_cmd.prev_r;
        w_icur[0]  = i_cmd.cur_l;
        w_icur[1]  = i_cmd.cur_r;
        w_iprev[0] = i_cmd.prev_l;
        w_iprev[1] = i_cmd.prev_r;
        for (int c = 0; c < 2; c++) begin
            w_diff[c] = {w_icur[c][SAMPLE_W-1], w_icur[c]}
                      - {w_iprev[c][SAMPLE_W-1], w_iprev[c]};
            w_mag[c]  = w_diff[c][DIFF_W-1] ? (~w_diff[c] + DIFF_W'(1)) : w_diff[c];

            // restoring divide, one quotient bit per cycle
            w_rsh[c]  = {r_rem[c], r_dvd[c][DIFF_W-1]};
            w_qbit[c] = (w_rsh[c] >= {1'b0, r_cmd.factor});
            w_nrem[c] = w_qbit[c] ? FACTOR_W'(w_rsh[c] - {1'b0, r_cmd.factor})
                                  : w_rsh[c][FACTOR_W-1:0];
            w_ndvd[c] = {r_dvd[c][DIFF_W-2:0], w_qbit[c]};

            // step from |d|*j/f to |d|*(j+1)/f
            w_rsum[c] = {1'b0, r_r[c]} + {1'b0, r_rem[c]};
            w_wrap[c] = (w_rsum[c] >= {1'b0, r_cmd.factor});

            // quotient truncates toward zero, so apply the sign after dividing
            w_off[c]  = r_neg[c] ? (~r_q[c] + DIFF_W'(1)) : r_q[c];
            w_ival[c] = w_prev[c] + w_off[c][SAMPLE_W-1:0];
        end
    end

    always_comb begin
        n_state     = r_state;
        w_load_cmd  = 1'b0;
        w_div_run   = 1'b0;
        w_div_done  = 1'b0;
        w_emit_i    = 1'b0;
        w_emit_last = 1'b0;
        unique case (r_state)
            BK_IDLE: begin
                if (i_cmd_valid) begin
                    w_load_cmd = 1'b1;
                    if (i_cmd.interp && (i_cmd.factor != FACTOR_W'(1))) begin
                        n_state = BK_DIV;
                    end else begin
                        n_state = BK_LAST;
                    end
                end
            end
            BK_DIV: begin
                w_div_run = 1'b1;
                if (r_cnt == DIV_CNT_W'(DIFF_W - 1)) begin
                    w_div_done = 1'b1;
                    n_state    = BK_INTERP;
                end
            end
            BK_INTERP: begin
                if (w_adv) begin
                    w_emit_i = 1'b1;
                    if (r_j == r_cmd.factor - FACTOR_W'(1)) begin
                        n_state = BK_LAST;
                    end
                end
            end
            BK_LAST: begin
                if (w_adv) begin
                    w_emit_last = 1'b1;
                    n_state     = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    assign o_pop = w_load_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= BK_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= (r_ovalid & ~i_ready) | w_emit_i | w_emit_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_cmd) begin
            r_cmd <= i_cmd;
            r_cnt <= '0;
            r_j   <= FACTOR_W'(1);
            for (int c = 0; c < 2; c++) begin
                r_neg[c] <= w_diff[c][DIFF_W-1];
                r_dvd[c] <= w_mag[c];
                r_rem[c] <= '0;
            end
        end
        if (w_div_run) begin
            r_cnt <= r_cnt + DIV_CNT_W'(1);
            for (int c = 0; c < 2; c++) begin
                r_dvd[c] <= w_ndvd[c];
                r_rem[c] <= w_nrem[c];
                if (w_div_done) begin
                    r_q[c] <= w_ndvd[c];
                    r_r[c] <= w_nrem[c];
                end
            end
        end
        if (w_emit_i) begin
            r_j <= r_j + FACTOR_W'(1);
            for (int c = 0; c < 2; c++) begin
                r_out[c] <= w_ival[c];
                if (w_wrap[c]) begin
                    r_r[c] <= FACTOR_W'(w_rsum[c] - {1'b0, r_cmd.factor});
                    r_q[c] <= r_q[c] + r_dvd[c] + DIFF_W'(1);
                end else begin
                    r_r[c] <= w_rsum[c][FACTOR_W-1:0];
                    r_q[c] <= r_q[c] + r_dvd[c];
                end
            end
            r_olast <= 1'b0;
        end
        if (w_emit_last) begin
            r_out[0] <= w_cur[0];
            r_out[1] <= w_cur[1];
            r_olast  <= 1'b1;
        end
    end

    assign o_valid = r_ovalid;
    assign o_left  = r_out[0];
    assign o_right = r_out[1];
    assign o_last  = r_olast;

    assign o_stat.interp_run = (r_state == BK_DIV) || (r_state == BK_INTERP);
    assign o_stat.cmd_interp = r_cmd.interp;

endmodule

### hw/rtl/audio_frame_rate_changer_core.sv
// flow: a passed frame is queued, loaded by the back end and registered to the output;
//   a slow-down frame above factor one first divides |cur - prev| by the factor in a
//   restoring divider, then gives one result per cycle within a run while i_ready holds;
//   the back end takes a new frame only when idle; skipped frames are never queued
// reset: synchronous active-low i_rst_n clears registers to mode 0, factor 1,
//   one channel, 2-byte samples, previous frame and phase zero, queue empty
`timescale 1ns / 1ps
module audio_frame_rate_changer_core
    import afrc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wen,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [SAMPLE_W-1:0]   i_sample_left,
    input  logic [SAMPLE_W-1:0]   i_sample_right,
    input  logic                  i_stream_start,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [SAMPLE_W-1:0]   o_out_left,
    output logic [SAMPLE_W-1:0]   o_out_right,
    output logic                  o_last_of_run
);

    logic       r_mode;
    logic [6:0] r_factor;
    logic [1:0] r_chan;
    logic [2:0] r_bytes;
    t_cfg       w_cfg;

    logic       w_push, w_pop;
    t_cmd       w_cmd_in, w_cmd_out;
    t_fifo_stat w_fstat;
    t_back_stat w_bstat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_SPEED_UP;
            r_factor <= 7'd1;
            r_chan   <= 2'd1;
            r_bytes  <= 3'd2;
        end else if (i_cfg_wen) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_MODE:     r_mode   <= i_cfg_data[0];
                CFG_FACTOR:   r_factor <= i_cfg_data[6:0];
                CFG_CHANNELS: r_chan   <= i_cfg_data[1:0];
                CFG_BYTES:    r_bytes  <= i_cfg_data[2:0];
                default:      r_mode   <= r_mode;
            endcase
        end
    end

    always_comb begin
        w_cfg.mode = r_mode;
        if (r_factor == 7'd0) begin
            w_cfg.factor = FACTOR_W'(1);
        end else if (32'(r_factor) > MAX_FACTOR) begin
            w_cfg.factor = FACTOR_W'(MAX_FACTOR);
        end else begin
            w_cfg.factor = FACTOR_W'(r_factor);
        end
        w_cfg.two = r_chan[1];
        if (r_bytes == 3'd0) begin
            w_cfg.nbytes = 3'd1;
        end else if (r_bytes > 3'd4) begin
            w_cfg.nbytes = 3'd4;
        end else begin
            w_cfg.nbytes = r_bytes;
        end
    end

    assign o_ready = ~w_fstat.full;

    afrc_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (w_cfg),
        .i_valid        (i_valid),
        .i_full         (w_fstat.full),
        .i_sample_left  (i_sample_left),
        .i_sample_right (i_sample_right),
        .i_stream_start (i_stream_start),
        .o_push         (w_push),
        .o_cmd          (w_cmd_in)
    );

    afrc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_cmd_in),
        .i_pop   (w_pop),
        .o_data  (w_cmd_out),
        .o_stat  (w_fstat)
    );

    afrc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd_out),
        .i_cmd_valid (~w_fstat.empty),
        .o_pop       (w_pop),
        .i_ready     (i_ready),
        .o_valid     (o_valid),
        .o_left      (o_out_left),
        .o_right     (o_out_right),
        .o_last      (o_last_of_run),
        .o_stat      (w_bstat)
    );

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_fstat.full)
        else $error("queue written while full");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_fstat.empty)
        else $error("queue read while empty");

    a_interp_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_bstat.interp_run |-> w_bstat.cmd_interp)
        else $error("interpolation running on a pass-through command");

endmodule
